// ===== hw/rtl/hmq_pkg.sv =====
// ============================================================================
// hmq_pkg
// Shared types and constants of the binary min-heap queue: request and
// response beats, heap entry layout, memory port bundle and operation codes.
// ============================================================================
package hmq_pkg;

    // Heap geometry
    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int IDX_W    = $clog2(CAPACITY + 1);
    localparam int COUNT_W  = 11;

    // Operation codes
    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_PEEK   = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // One heap slot: key above the two payload words
    typedef struct packed {
        logic [31:0] key;
        logic [15:0] value_a;
        logic [15:0] value_b;
    } t_entry;

    // Request beat
    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] in_key;
        logic [15:0] in_value_a;
        logic [15:0] in_value_b;
    } t_req;

    // Response beat
    typedef struct packed {
        logic [1:0]         status;
        logic [31:0]        out_key;
        logic [15:0]        out_value_a;
        logic [15:0]        out_value_b;
        logic [COUNT_W-1:0] entry_count;
        logic               is_empty;
    } t_rsp;

    // Heap memory port: one write, one read per cycle
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        t_entry            wdata;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    // Completion info from the sequencer
    typedef struct packed {
        logic             vld;
        logic [1:0]       status;
        t_entry           entry;
        logic [IDX_W-1:0] count;
    } t_fin;

endpackage

// ===== hw/rtl/hmq_store.sv =====
// ============================================================================
// hmq_store
// Heap entry memory: one write port and one read port, read data registered.
// Slot index i of the heap lives at address i-1.
// ============================================================================
module hmq_store (
    input  logic              i_clk,
    input  hmq_pkg::t_mem_req i_mem,
    output hmq_pkg::t_entry   o_rdata
);
    import hmq_pkg::*;

    t_entry r_mem [CAPACITY];
    t_entry r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_mem.we) begin
            r_mem[i_mem.waddr] <= i_mem.wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_mem.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/hmq_seq.sv =====
// ============================================================================
// hmq_seq
// Heap sequencer: owns the occupancy and walks sift-up and sift-down one level
// at a time through the shared key comparator. The moving entry is held in a
// register and only written once its final slot is known.
// ============================================================================
module hmq_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  hmq_pkg::t_req     i_req,
    input  hmq_pkg::t_entry   i_rdata,
    output logic              o_busy,
    output hmq_pkg::t_mem_req o_mem,
    output hmq_pkg::t_fin     o_fin
);
    import hmq_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_UP_CHK  = 4'd1;
    localparam logic [3:0] S_UP_CMP  = 4'd2;
    localparam logic [3:0] S_RM_ROOT = 4'd3;
    localparam logic [3:0] S_RM_LAST = 4'd4;
    localparam logic [3:0] S_DN_CHK  = 4'd5;
    localparam logic [3:0] S_DN_L    = 4'd6;
    localparam logic [3:0] S_DN_R    = 4'd7;
    localparam logic [3:0] S_DN_CMP  = 4'd8;

    // Slot index to memory address
    function automatic logic [ADDR_W-1:0] idx2addr(input logic [IDX_W:0] idx);
        logic [IDX_W:0] t;
        t = idx - (IDX_W+1)'(1);
        return t[ADDR_W-1:0];
    endfunction

    logic [3:0]       r_state, n_state;
    logic [IDX_W-1:0] r_occ, n_occ;
    logic [IDX_W-1:0] r_hole, n_hole;
    logic [IDX_W-1:0] r_cidx, n_cidx;
    logic             r_right, n_right;
    logic [1:0]       r_func, n_func;
    t_entry           r_mov, n_mov;
    t_entry           r_child, n_child;
    t_entry           r_res, n_res;

    logic [31:0]      cmp_a, cmp_b;
    logic             cmp_lt;
    logic [IDX_W:0]   lidx;

    // Shared key comparator
    assign cmp_lt = cmp_a < cmp_b;
    assign lidx   = {r_hole, 1'b0};

    // Operand select for the comparator
    always_comb begin
        cmp_a = r_child.key;
        cmp_b = r_mov.key;
        unique case (r_state)
            S_UP_CMP: begin
                cmp_a = r_mov.key;
                cmp_b = i_rdata.key;
            end
            S_DN_R: begin
                cmp_a = r_child.key;
                cmp_b = i_rdata.key;
            end
            default: begin
                cmp_a = r_child.key;
                cmp_b = r_mov.key;
            end
        endcase
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        n_occ   = r_occ;
        n_hole  = r_hole;
        n_cidx  = r_cidx;
        n_right = r_right;
        n_func  = r_func;
        n_mov   = r_mov;
        n_child = r_child;
        n_res   = r_res;
        o_mem   = '0;
        o_fin   = '0;
        o_fin.entry = r_res;
        o_fin.count = r_occ;

        unique case (r_state)
            S_IDLE: begin
                o_fin.entry = '0;
                if (i_start) begin
                    n_res = '0;
                    unique case (i_req.func)
                        FUNC_INSERT: begin
                            if (r_occ >= IDX_W'(CAPACITY)) begin
                                o_fin.vld    = 1'b1;
                                o_fin.status = ST_FULL;
                            end else begin
                                n_occ   = r_occ + IDX_W'(1);
                                n_hole  = r_occ + IDX_W'(1);
                                n_mov   = '{key: i_req.in_key, value_a: i_req.in_value_a,
                                            value_b: i_req.in_value_b};
                                n_state = S_UP_CHK;
                            end
                        end
                        FUNC_REMOVE, FUNC_PEEK: begin
                            // root read is already in flight (address zero)
                            if (r_occ == '0) begin
                                o_fin.vld    = 1'b1;
                                o_fin.status = ST_EMPTY;
                            end else begin
                                n_func  = i_req.func;
                                n_state = S_RM_ROOT;
                            end
                        end
                        default: begin
                            o_fin.vld    = 1'b1;
                            o_fin.status = ST_OK;
                        end
                    endcase
                end
            end

            // sift-up: fetch parent or settle at the root
            S_UP_CHK: begin
                if (r_hole > IDX_W'(1)) begin
                    o_mem.raddr = idx2addr({1'b0, r_hole >> 1});
                    n_state     = S_UP_CMP;
                end else begin
                    o_mem.we    = 1'b1;
                    o_mem.waddr = idx2addr({1'b0, r_hole});
                    o_mem.wdata = r_mov;
                    o_fin.vld   = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            // sift-up: pull parent down while new key is strictly smaller
            S_UP_CMP: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = idx2addr({1'b0, r_hole});
                if (cmp_lt) begin
                    o_mem.wdata = i_rdata;
                    n_hole      = r_hole >> 1;
                    n_state     = S_UP_CHK;
                end else begin
                    o_mem.wdata = r_mov;
                    o_fin.vld   = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            // root is on the read port
            S_RM_ROOT: begin
                n_res       = i_rdata;
                o_fin.entry = i_rdata;
                if (r_func == FUNC_PEEK) begin
                    o_fin.vld = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    o_mem.raddr = idx2addr({1'b0, r_occ});
                    n_state     = S_RM_LAST;
                end
            end

            // last entry becomes the moving entry, hole at the root
            S_RM_LAST: begin
                n_mov   = i_rdata;
                n_occ   = r_occ - IDX_W'(1);
                n_hole  = IDX_W'(1);
                n_state = S_DN_CHK;
            end

            // sift-down: fetch left child or settle
            S_DN_CHK: begin
                if (lidx > {1'b0, r_occ}) begin
                    o_mem.we    = 1'b1;
                    o_mem.waddr = idx2addr({1'b0, r_hole});
                    o_mem.wdata = r_mov;
                    o_fin.vld   = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    o_mem.raddr = idx2addr(lidx);
                    n_cidx      = lidx[IDX_W-1:0];
                    n_right     = lidx < {1'b0, r_occ};
                    n_state     = S_DN_L;
                end
            end

            // left child arrives; fetch right child if present
            S_DN_L: begin
                n_child = i_rdata;
                if (r_right) begin
                    o_mem.raddr = r_cidx[ADDR_W-1:0];
                    n_state     = S_DN_R;
                end else begin
                    n_state = S_DN_CMP;
                end
            end

            // right child wins unless left key is strictly smaller
            S_DN_R: begin
                if (!cmp_lt) begin
                    n_child = i_rdata;
                    n_cidx  = r_cidx + IDX_W'(1);
                end
                n_state = S_DN_CMP;
            end

            // swap down while child key is strictly smaller
            S_DN_CMP: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = idx2addr({1'b0, r_hole});
                if (cmp_lt) begin
                    o_mem.wdata = r_child;
                    n_hole      = r_cidx;
                    n_state     = S_DN_CHK;
                end else begin
                    o_mem.wdata = r_mov;
                    o_fin.vld   = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = r_state != S_IDLE;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_occ   <= '0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_hole  <= n_hole;
        r_cidx  <= n_cidx;
        r_right <= n_right;
        r_func  <= n_func;
        r_mov   <= n_mov;
        r_child <= n_child;
        r_res   <= n_res;
    end

    // Occupancy stays within the heap
    a_occ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= IDX_W'(CAPACITY))
        else $error("occupancy above capacity");

    // No heap writes while idle
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !o_mem.we)
        else $error("heap write while idle");

    // Completion always returns to idle
    a_fin_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_fin.vld |=> (r_state == S_IDLE))
        else $error("sequencer not idle after completion");

    // Full status only when the heap is full
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_fin.vld && o_fin.status == ST_FULL) |-> (r_occ == IDX_W'(CAPACITY)))
        else $error("full reported below capacity");

    // Sift-up hole stays inside the occupied range
    a_up_hole: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UP_CHK || r_state == S_UP_CMP) |->
            (r_hole != '0 && r_hole <= r_occ))
        else $error("sift-up hole out of range");

endmodule

// ===== hw/rtl/binary_min_heap_queue.sv =====
// Full, empty or unknown func requests complete from idle without touching the heap;
// peek returns the root read; insert climbs one level at a time and remove
// descends one level at a time. Each sift-up level costs a registered read of
// the parent plus one key compare; each sift-down level reads the children
// and compares keys. One request at a time; busy is high until o_done.
// Sync active-low reset empties the heap; memory is not cleared.
// ============================================================================
// binary_min_heap_queue
// Binary min-heap priority queue of key/value entries with insert, remove-min
// and peek. Sequencer plus heap memory; the response beat is registered here.
// ============================================================================
module binary_min_heap_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  hmq_pkg::t_req  i_req,
    output logic           busy,
    output logic           o_done,
    output hmq_pkg::t_rsp  o_rsp
);
    import hmq_pkg::*;

    t_mem_req mem_req;
    t_entry   mem_rdata;
    t_fin     fin;
    logic     r_done;
    t_rsp     r_rsp;

    hmq_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_req   (i_req),
        .i_rdata (mem_rdata),
        .o_busy  (busy),
        .o_mem   (mem_req),
        .o_fin   (fin)
    );

    hmq_store u_store (
        .i_clk   (i_clk),
        .i_mem   (mem_req),
        .o_rdata (mem_rdata)
    );

    // Response strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= fin.vld;
        end
    end

    // Response beat
    always_ff @(posedge i_clk) begin
        if (fin.vld) begin
            r_rsp.status      <= fin.status;
            r_rsp.out_key     <= fin.entry.key;
            r_rsp.out_value_a <= fin.entry.value_a;
            r_rsp.out_value_b <= fin.entry.value_b;
            r_rsp.entry_count <= COUNT_W'(fin.count);
            r_rsp.is_empty    <= fin.count == '0;
        end
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb
// Self-checking bench for the binary min-heap queue. Requests are sent on the
// start/busy handshake and each response beat is compared, field by field,
// against a behavioral heap kept in step with the accepted requests. Covers
// empty and full corner cases, key ties in both sift directions, the unused
// operation code, random traffic, a fill to capacity and a partial drain.
// ============================================================================
module tb;
    import hmq_pkg::*;

    localparam int         CLK_PERIOD  = 10;
    localparam int         RST_CYCLES  = 12;
    localparam int         STALL_LIMIT = 5000;
    localparam int         TAIL_CYCLES = 60;
    localparam int         PRINT_MAX   = 60;
    // func encoding with no operation behind it
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    logic  i_clk   = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  start   = 1'b0;
    t_req  req_bus = '0;
    logic  busy;
    logic  o_done;
    t_rsp  o_rsp;

    // Behavioral heap, one-based like the hardware
    t_entry heap_mem [1:CAPACITY];
    int     heap_cnt = 0;

    t_rsp   rsp_expected [$];
    t_rsp   rsp_want;
    int     err_count    = 0;
    int     stall_cycles = 0;
    bit     idle_on      = 1'b1;

    binary_min_heap_queue i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (req_bus),
        .busy    (busy),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Heap model
    // ------------------------------------------------------------------------
    function automatic void heap_swap(input int a, input int b);
        t_entry tmp;
        tmp         = heap_mem[a];
        heap_mem[a] = heap_mem[b];
        heap_mem[b] = tmp;
    endfunction

    // climb while strictly smaller than the parent
    function automatic void heap_sift_up(input int pos);
        while (pos > 1 && heap_mem[pos].key < heap_mem[pos / 2].key) begin
            heap_swap(pos, pos / 2);
            pos = pos / 2;
        end
    endfunction

    // descend toward the smaller child; equal child keys pick the right one
    function automatic void heap_sift_down(input int pos);
        int kid;
        bit done;
        done = 1'b0;
        while (!done) begin
            kid = 2 * pos;
            if (kid > heap_cnt) begin
                done = 1'b1;
            end else begin
                if (kid + 1 <= heap_cnt && !(heap_mem[kid].key < heap_mem[kid + 1].key))
                    kid = kid + 1;
                if (heap_mem[pos].key > heap_mem[kid].key) begin
                    heap_swap(pos, kid);
                    pos = kid;
                end else begin
                    done = 1'b1;
                end
            end
        end
    endfunction

    function automatic t_rsp predict_response(input t_req req);
        t_rsp   rsp;
        t_entry top;
        rsp = '0;
        top = '0;
        case (req.func)
            FUNC_INSERT: begin
                if (heap_cnt >= CAPACITY) begin
                    rsp.status = ST_FULL;
                end else begin
                    heap_cnt++;
                    heap_mem[heap_cnt] = '{key: req.in_key, value_a: req.in_value_a,
                                           value_b: req.in_value_b};
                    heap_sift_up(heap_cnt);
                end
            end
            FUNC_REMOVE, FUNC_PEEK: begin
                if (heap_cnt == 0) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    top = heap_mem[1];
                    if (req.func == FUNC_REMOVE) begin
                        heap_mem[1] = heap_mem[heap_cnt];
                        heap_cnt--;
                        heap_sift_down(1);
                    end
                end
            end
            default: ;
        endcase
        rsp.out_key     = top.key;
        rsp.out_value_a = top.value_a;
        rsp.out_value_b = top.value_b;
        rsp.entry_count = heap_cnt[COUNT_W-1:0];
        rsp.is_empty    = (heap_cnt == 0);
        return rsp;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic t_req make_req(input logic [1:0] f, input logic [31:0] k,
                                      input logic [15:0] a, input logic [15:0] b);
        t_req req;
        req.func       = f;
        req.in_key     = k;
        req.in_value_a = a;
        req.in_value_b = b;
        return req;
    endfunction

    // narrow keys most of the time so ties are common
    function automatic logic [31:0] pick_key();
        if ($urandom_range(99) < 60)
            return $urandom_range(31);
        return $urandom;
    endfunction

    // random request; the last three percent use the unused func code
    function automatic t_req pick_req(input int ins_pct, input int rem_pct);
        int         roll;
        logic [1:0] f;
        roll = $urandom_range(99);
        if (roll < ins_pct)
            f = FUNC_INSERT;
        else if (roll < ins_pct + rem_pct)
            f = FUNC_REMOVE;
        else if (roll < 97)
            f = FUNC_PEEK;
        else
            f = FUNC_UNUSED;
        return make_req(f, pick_key(), 16'($urandom), 16'($urandom));
    endfunction

    // drive one request beat and wait for it to be taken
    task automatic send_req(input t_req req);
        if (idle_on && $urandom_range(99) < 18) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 18);
        end
        start   <= 1'b1;
        req_bus <= req;
        do @(posedge i_clk); while (busy);
        rsp_expected.push_back(predict_response(req));
    endtask

    // ------------------------------------------------------------------------
    // Response checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (err_count < PRINT_MAX)
            $display("%0t: %s mismatch: got 0x%0h, want 0x%0h", $realtime, what, got, want);
        err_count++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done !== 1'b0) begin
            if (rsp_expected.size() == 0) begin
                report_mismatch("unexpected beat", 64'(o_rsp), '0);
            end else begin
                rsp_want = rsp_expected.pop_front();
                if (o_rsp.status !== rsp_want.status)
                    report_mismatch("status", 64'(o_rsp.status), 64'(rsp_want.status));
                if (o_rsp.out_key !== rsp_want.out_key)
                    report_mismatch("out_key", 64'(o_rsp.out_key), 64'(rsp_want.out_key));
                if (o_rsp.out_value_a !== rsp_want.out_value_a)
                    report_mismatch("out_value_a", 64'(o_rsp.out_value_a),
                                    64'(rsp_want.out_value_a));
                if (o_rsp.out_value_b !== rsp_want.out_value_b)
                    report_mismatch("out_value_b", 64'(o_rsp.out_value_b),
                                    64'(rsp_want.out_value_b));
                if (o_rsp.entry_count !== rsp_want.entry_count)
                    report_mismatch("entry_count", 64'(o_rsp.entry_count),
                                    64'(rsp_want.entry_count));
                if (o_rsp.is_empty !== rsp_want.is_empty)
                    report_mismatch("is_empty", 64'(o_rsp.is_empty), 64'(rsp_want.is_empty));
            end
        end
    end

    // Watchdog: cycles without an accepted beat in either direction
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done === 1'b1) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("[binary_min_heap_queue] ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // requests on an empty heap
    task automatic test_empty_requests();
        send_req(make_req(FUNC_PEEK, '1, '1, '1));
        send_req(make_req(FUNC_REMOVE, '0, '0, '0));
        send_req(make_req(FUNC_UNUSED, '1, '1, '1));
    endtask

    // field extremes, key ties on the way up and down
    task automatic test_directed_order();
        send_req(make_req(FUNC_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
        send_req(make_req(FUNC_INSERT, 32'h0, 16'h0, 16'h0));
        // equal key must not climb past the root
        send_req(make_req(FUNC_INSERT, 32'h0, 16'h1234, 16'h5678));
        send_req(make_req(FUNC_PEEK, '0, '0, '0));
        send_req(make_req(FUNC_UNUSED, '1, '1, '1));
        repeat (4) send_req(make_req(FUNC_REMOVE, '1, '1, '1));
        // equal child keys: sift-down must take the right child
        send_req(make_req(FUNC_INSERT, 32'd1, 16'h0001, 16'h0001));
        send_req(make_req(FUNC_INSERT, 32'd7, 16'h00AA, 16'h000A));
        send_req(make_req(FUNC_INSERT, 32'd7, 16'h00BB, 16'h000B));
        send_req(make_req(FUNC_INSERT, 32'd9, 16'h0009, 16'h0009));
        repeat (4) send_req(make_req(FUNC_REMOVE, '0, '0, '0));
        send_req(make_req(FUNC_PEEK, '0, '0, '0));
    endtask

    task automatic test_random_traffic(input int n_items);
        repeat (n_items) send_req(pick_req(45, 35));
    endtask

    // back-to-back inserts up to capacity, then inserts into a full heap
    task automatic test_fill_to_capacity();
        idle_on = 1'b0;
        while (heap_cnt < CAPACITY)
            send_req(make_req(FUNC_INSERT, pick_key(), 16'($urandom), 16'($urandom)));
        repeat (6) send_req(make_req(FUNC_INSERT, $urandom, 16'($urandom), 16'($urandom)));
        send_req(make_req(FUNC_PEEK, $urandom, 16'($urandom), 16'($urandom)));
        idle_on = 1'b1;
    endtask

    // deep sifts while hovering at the full mark
    task automatic test_full_churn(input int n_items);
        repeat (n_items) send_req(pick_req(50, 45));
    endtask

    task automatic test_drain(input int n_items);
        repeat (n_items) send_req(pick_req(15, 80));
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_requests();
        test_directed_order();
        test_random_traffic(120);
        test_fill_to_capacity();
        test_full_churn(60);
        test_drain(150);

        start <= 1'b0;
        while (rsp_expected.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (err_count == 0)
            $display("[binary_min_heap_queue] OK");
        else
            $display("[binary_min_heap_queue] ERROR");
        $finish;
    end

endmodule
